// File: hw/rtl/sfrc_pkg.sv
// Package for the serial frame receiver with checksum.
// Holds the item and result structs, header bytes and byte position codes.
// No dependencies.
`timescale 1ns / 1ps

package sfrc_pkg;

  localparam int unsigned POS_W = 17;

  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hF1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // byte position within the frame; idle means no frame in progress
  localparam logic [POS_W-1:0] POS_IDLE    = 17'd0;
  localparam logic [POS_W-1:0] POS_HDR2    = 17'd1;
  localparam logic [POS_W-1:0] POS_CMD     = 17'd2;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd4;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } sfrc_in_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_length;
    logic        frame_end;
    logic        checksum_ok;
  } sfrc_out_t;

endpackage

// File: hw/rtl/serial_frame_receiver_checksum_core.sv
// Top level of the serial frame receiver with additive checksum.
// Depends on sfrc_pkg, sfrc_in_reg, sfrc_parser and sfrc_out_reg.
`timescale 1ns / 1ps

// Takes one item per cycle while not stalled (a UART byte or a time tick) and
// parses frames of the form FF F1, command, 16-bit big-endian length, payload,
// checksum. Each payload byte comes out as one result; the checksum byte gives
// an end result whose checksum_ok flag tells the consumer whether to keep the
// frame. Ticks and header bytes give no result; a dropped frame gives no end
// result. An accepted item is held in the input register until it steps through
// the parser, which loads its result into the result register and updates the
// frame state; items without a result step even while the output side stalls.
// rx_timeout_ticks (timeout_q) is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce this.

module serial_frame_receiver_checksum_core import sfrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sfrc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sfrc_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] timeout_q;
  logic        item_valid;
  sfrc_in_t    item;
  logic        res_valid;
  sfrc_out_t   res;
  logic        out_ready;
  logic        step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // items without a result never wait for the output side
  assign step = item_valid && (!res_valid || out_ready);

  sfrc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .take_i  (step),
    .valid_o (item_valid),
    .data_o  (item)
  );

  sfrc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .step_i      (step),
    .timeout_i   (timeout_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfrc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .data_i  (res),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/sfrc_in_reg.sv
// Input register for the frame receiver: holds one accepted item.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

module sfrc_in_reg import sfrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  sfrc_in_t data_i,
  input  logic     take_i,
  output logic     valid_o,
  output sfrc_in_t data_o
);

  logic     valid_q, valid_d;
  sfrc_in_t data_q;
  logic     accept;

  // full and not drained this cycle
  assign stall_o = valid_q && !take_i;
  assign accept  = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/sfrc_parser.sv
// Frame parser: frame state registers and the per-item step logic.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

module sfrc_parser import sfrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sfrc_in_t    item_i,
  input  logic        step_i,
  input  logic [15:0] timeout_i,
  output logic        res_valid_o,
  output sfrc_out_t   res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;
  logic [7:0]       sum_q, sum_d;
  logic [15:0]      idle_q, idle_d;

  always_comb begin
    logic [15:0]      idle_inc;
    logic [POS_W-1:0] idx;
    logic [7:0]       b;

    pos_d  = pos_q;
    cmd_d  = cmd_q;
    len_d  = len_q;
    sum_d  = sum_q;
    idle_d = idle_q;
    b      = item_i.rx_byte;
    idx    = pos_q - POS_PAYLOAD;
    idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;

    res_valid_o          = (item_i.kind == KIND_BYTE) && (pos_q >= POS_PAYLOAD);
    res_o.command        = cmd_q;
    res_o.payload_length = len_q;
    res_o.payload_byte   = 8'd0;
    res_o.payload_index  = 16'd0;
    res_o.frame_end      = 1'b0;
    res_o.checksum_ok    = 1'b0;

    if (item_i.kind == KIND_TICK) begin
      idle_d = idle_inc;
      if (pos_q != POS_IDLE && idle_inc > timeout_i) begin
        pos_d = POS_IDLE;
        sum_d = 8'd0;
      end
    end else if (pos_q == POS_IDLE) begin
      // stray bytes while idle are ignored
      if (b == HDR_FIRST) begin
        sum_d  = b;
        pos_d  = POS_HDR2;
        idle_d = 16'd0;
      end
    end else if (pos_q == POS_HDR2) begin
      if (b == HDR_SECOND) begin
        sum_d  = sum_q + b;
        pos_d  = POS_CMD;
        idle_d = 16'd0;
      end else begin
        pos_d = POS_IDLE;
        sum_d = 8'd0;
      end
    end else if (pos_q < POS_PAYLOAD) begin
      if (pos_q == POS_CMD) begin
        cmd_d = b;
      end else if (pos_q == POS_LEN_HI) begin
        len_d = {b, 8'd0};
      end else begin
        len_d = {len_q[15:8], b};
      end
      sum_d  = sum_q + b;
      pos_d  = pos_q + 17'd1;
      idle_d = 16'd0;
    end else if (idx < {1'b0, len_q}) begin
      res_o.payload_byte  = b;
      res_o.payload_index = idx[15:0];
      sum_d  = sum_q + b;
      pos_d  = pos_q + 17'd1;
      idle_d = 16'd0;
    end else begin
      // checksum byte closes the frame
      res_o.frame_end   = 1'b1;
      res_o.checksum_ok = (b == sum_q);
      pos_d  = POS_IDLE;
      sum_d  = 8'd0;
      idle_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_IDLE;
      cmd_q  <= 8'd0;
      len_q  <= 16'd0;
      sum_q  <= 8'd0;
      idle_q <= 16'd0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
      idle_q <= idle_d;
    end
  end

endmodule

// File: hw/rtl/sfrc_out_reg.sv
// Result register for the frame receiver, drives the output channel.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

module sfrc_out_reg import sfrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  sfrc_out_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      stall_i,
  output sfrc_out_t data_o
);

  logic      valid_q, valid_d;
  sfrc_out_t data_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/sfrc_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
// Depends on sfrc_pkg and serial_frame_receiver_checksum_core.
`timescale 1ns / 1ps

module sfrc_checker import sfrc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input sfrc_out_t out_data_o
);

  // input side only backs up when the result register is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |->
      out_data_o.payload_byte == 8'd0 && out_data_o.payload_index == 16'd0)
    else $error("end result carries payload data");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_end |->
      !out_data_o.checksum_ok &&
      out_data_o.payload_index < out_data_o.payload_length)
    else $error("payload result out of range");

endmodule

bind serial_frame_receiver_checksum_core sfrc_checker u_sfrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: bench/serial_frame_receiver_checksum_core_tb.sv
// Testbench for serial_frame_receiver_checksum_core: drives UART bytes and ticks,
// tracks the frame parser state alongside the block and checks every result.
// Depends on sfrc_pkg and the core RTL.
`timescale 1ns / 1ps

module serial_frame_receiver_checksum_core_tb;
  import sfrc_pkg::*;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned MAX_REPORTS    = 40;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  sfrc_in_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  sfrc_out_t   out_data_o;

  serial_frame_receiver_checksum_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // parser state tracked on every accepted transfer
  logic [POS_W-1:0] frame_pos     = POS_IDLE;
  logic [7:0]       frame_cmd     = '0;
  logic [15:0]      frame_len     = '0;
  logic [7:0]       frame_sum     = '0;
  logic [15:0]      idle_ticks    = '0;
  logic [15:0]      timeout_ticks = TIMEOUT_RESET;

  sfrc_out_t   pending_results[$];
  int unsigned items_sent = 0;
  int unsigned errors     = 0;
  int unsigned reports    = 0;
  int          burst_left = 0;
  bit          hold_req   = 1'b0;

  task automatic take_byte(input logic [7:0] b);
    frame_sum  = frame_sum + b;
    frame_pos  = frame_pos + 1'b1;
    idle_ticks = '0;
  endtask

  task automatic drop_frame();
    frame_pos = POS_IDLE;
    frame_sum = '0;
  endtask

  task automatic advance_parser(input sfrc_in_t it);
    sfrc_out_t        r;
    logic [POS_W-1:0] idx;
    if (it.kind == KIND_TICK) begin
      if (idle_ticks != IDLE_MAX) idle_ticks++;
      if (frame_pos != POS_IDLE && idle_ticks > timeout_ticks) drop_frame();
    end else begin
      case (frame_pos)
        POS_IDLE: begin
          if (it.rx_byte == HDR_FIRST) begin
            frame_sum = '0;
            take_byte(it.rx_byte);
          end
        end
        POS_HDR2: begin
          if (it.rx_byte == HDR_SECOND) take_byte(it.rx_byte);
          else drop_frame();
        end
        POS_CMD: begin
          frame_cmd = it.rx_byte;
          take_byte(it.rx_byte);
        end
        POS_LEN_HI: begin
          frame_len = {it.rx_byte, 8'h00};
          take_byte(it.rx_byte);
        end
        POS_LEN_LO: begin
          frame_len[7:0] = it.rx_byte;
          take_byte(it.rx_byte);
        end
        default: begin
          idx = frame_pos - POS_PAYLOAD;
          r.command        = frame_cmd;
          r.payload_length = frame_len;
          if (idx < {1'b0, frame_len}) begin
            r.payload_byte  = it.rx_byte;
            r.payload_index = idx[15:0];
            r.frame_end     = 1'b0;
            r.checksum_ok   = 1'b0;
            take_byte(it.rx_byte);
          end else begin
            r.payload_byte  = '0;
            r.payload_index = '0;
            r.frame_end     = 1'b1;
            r.checksum_ok   = (it.rx_byte == frame_sum);
            idle_ticks      = '0;
            drop_frame();
          end
          pending_results = {pending_results, r};
        end
      endcase
    end
  endtask

  // sender: bursts of random length with random gaps between them
  task automatic send_item(input logic kind, input logic [7:0] b);
    sfrc_in_t it;
    int       gap;
    it.kind    = kind;
    it.rx_byte = b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    advance_parser(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, b);
  endtask

  // rx_byte is don't-care on a tick, so it gets random content
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // one frame; cut > 0 stops after that many frame bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input bit bad_sum, input int unsigned tick_odds,
                            input bit extreme_bytes, input int unsigned cut);
    int unsigned total;
    int unsigned j;
    logic [7:0]  b;
    total = 6 + len;
    for (j = 0; j < total; j++) begin
      if (cut != 0 && j >= cut) break;
      case (j)
        0: b = HDR_FIRST;
        1: b = HDR_SECOND;
        2: b = cmd;
        3: b = len[15:8];
        4: b = len[7:0];
        default: begin
          if (j == total - 1) b = bad_sum ? frame_sum ^ 8'($urandom_range(1, 255)) : frame_sum;
          else if (extreme_bytes) b = ((j - 5) % 2 == 0) ? 8'h00 : 8'hFF;
          else b = 8'($urandom_range(0, 255));
        end
      endcase
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) send_ticks($urandom_range(1, 3));
      send_byte(b);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    timeout_ticks = value;
  endtask

  // drop a half-received frame so the next one starts clean, if the timeout is below 1000 ticks
  task automatic resync();
    if (frame_pos != POS_IDLE && timeout_ticks < 16'd1000) send_ticks(timeout_ticks + 1);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    sfrc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data_o);
        end
      end else begin
        want = pending_results.pop_front();
        compare_field("command", 16'(want.command), 16'(out_data_o.command));
        compare_field("payload_byte", 16'(want.payload_byte), 16'(out_data_o.payload_byte));
        compare_field("payload_index", want.payload_index, out_data_o.payload_index);
        compare_field("payload_length", want.payload_length, out_data_o.payload_length);
        compare_field("frame_end", 16'(want.frame_end), 16'(out_data_o.frame_end));
        compare_field("checksum_ok", 16'(want.checksum_ok), 16'(out_data_o.checksum_ok));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  int          stall_left = 0;
  int          hold_left  = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(4, 80);
        stall_mode = stall_mode_e'($urandom_range(0, 3));
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, stuck_cycles);
      $display("serial_frame_receiver_checksum_core regression: fail");
      $finish;
    end
  end

  // reset value of the timeout: 100 ticks keep the frame, 101 drop it
  task automatic test_reset_timeout();
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h01);
    send_ticks(100);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hAA);
    send_byte(frame_sum);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h02);
    send_ticks(101);
    send_byte(8'h00);
  endtask

  task automatic test_frame_cases();
    // stray bytes while idle
    send_byte(8'h00);
    send_byte(HDR_SECOND);
    send_byte(8'h7F);
    // zero length, good and bad checksum, command extremes
    send_frame(8'h00, 16'd0, 1'b0, 0, 1'b0, 0);
    send_frame(8'hFF, 16'd0, 1'b1, 0, 1'b0, 0);
    // a repeated first header byte drops the frame and does not restart it
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_frame(8'h80, 16'd2, 1'b0, 0, 1'b1, 0);
  endtask

  task automatic test_timeout_settings();
    write_timeout(16'd1);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h05);
    send_ticks(1);
    send_byte(8'h00);
    send_ticks(2);
    send_byte(8'h03);
    // zero drops a partial frame on the first tick
    write_timeout(16'd0);
    send_byte(HDR_FIRST);
    send_ticks(1);
    send_byte(HDR_SECOND);
    // the largest timeout keeps the frame through a long idle stretch
    write_timeout(16'hFFFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h06);
    send_byte(8'h00);
    send_byte(8'h01);
    send_ticks(300);
    send_byte(8'h5A);
    send_byte(frame_sum);
    // declared length at its maximum, then timed out
    write_timeout(16'd3);
    send_frame(8'h11, 16'hFFFF, 1'b0, 0, 1'b0, 8);
    send_ticks(4);
  endtask

  task automatic run_random_phase(input logic [15:0] timeout, input bit frames_only);
    int unsigned target;
    int unsigned pick;
    logic [15:0] len;
    write_timeout(timeout);
    target = items_sent + RANDOM_ITEMS / 4;
    while (items_sent < target) begin
      pick = frames_only ? 0 : $urandom_range(0, 15);
      len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(9, 48))
                                         : 16'($urandom_range(0, 8));
      case (pick)
        10: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
              0: send_byte(HDR_FIRST);
              1: send_byte(HDR_SECOND);
              default: send_byte(8'($urandom_range(0, 255)));
            endcase
          end
        end
        11: begin
          resync();
          send_byte(HDR_FIRST);
          send_byte(8'($urandom_range(0, 255)));
        end
        12: begin
          resync();
          len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
          send_frame(8'($urandom_range(0, 255)), len, 1'b0, 0, 1'b0,
                     $urandom_range(1, 8));
          send_ticks(timeout + 1);
        end
        13: send_ticks($urandom_range(1, 5));
        14: begin
          resync();
          send_frame(8'($urandom_range(0, 255)), len, 1'b0, 0, 1'b0,
                     $urandom_range(1, 6));
          send_frame(8'($urandom_range(0, 255)), len, 1'b0, 0, 1'b0, 0);
        end
        15: begin
          resync();
          send_frame(8'($urandom_range(0, 255)), len, 1'b0, 2, 1'b0, 0);
        end
        default: begin
          resync();
          send_frame(8'($urandom_range(0, 255)), len, ($urandom_range(0, 7) == 0), 6,
                     1'b0, 0);
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'($urandom_range(4, 40)), 1'b0);
    run_random_phase(16'hFFFF, 1'b1);
    run_random_phase(16'($urandom_range(1, 3)), 1'b0);
    run_random_phase(16'd100, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering frames
  task automatic test_backpressure();
    wait_idle();
    resync();
    hold_req = 1'b1;
    repeat (4) send_frame(8'($urandom_range(0, 255)), 16'd40, 1'b0, 0, 1'b0, 0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_timeout();
    test_frame_cases();
    test_timeout_settings();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("serial_frame_receiver_checksum_core regression: pass");
    end else begin
      $display("serial_frame_receiver_checksum_core regression: fail");
    end
    $finish;
  end

endmodule

// File: serial_frame_receiver_checksum_core.f
hw/rtl/sfrc_pkg.sv
hw/rtl/sfrc_in_reg.sv
hw/rtl/sfrc_parser.sv
hw/rtl/sfrc_out_reg.sv
hw/rtl/serial_frame_receiver_checksum_core.sv
hw/rtl/sfrc_checker.sv
bench/serial_frame_receiver_checksum_core_tb.sv
